### rtl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg: shared types and constants for the sorted list
// Capacity, count widths, request kinds, status codes and the control word
// that the top level broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 7;

  // request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  // control word seen by every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [VAL_W-1:0] val;
    logic [CNT_W-1:0] fill;
  } cell_ctrl_t;

endpackage

### rtl/slid_cell.sv
// ----------------------------------------------------------------------------
// slid_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast value and takes its own
// next value from itself, the left neighbor, the right neighbor or the value.
// ----------------------------------------------------------------------------
module slid_cell (
  input  logic                      clk_i,
  input  slid_pkg::cell_ctrl_t      ctrl_i,
  input  logic [slid_pkg::CNT_W-1:0] idx_i,
  input  logic [slid_pkg::VAL_W-1:0] left_entry_i,
  input  logic                      left_gt_i,
  input  logic [slid_pkg::VAL_W-1:0] right_entry_i,
  output logic [slid_pkg::VAL_W-1:0] entry_o,
  output logic                      gt_o,
  output logic                      eq_o
);
  import slid_pkg::*;

  logic [VAL_W-1:0] entry_q, entry_d;
  logic             valid;
  logic             at_end;
  logic             ge;

  // slot occupancy and compares against the broadcast value
  assign valid  = idx_i < ctrl_i.fill;
  assign at_end = idx_i == ctrl_i.fill;
  assign gt_o   = valid && (entry_q > ctrl_i.val);
  assign ge     = valid && (entry_q >= ctrl_i.val);
  assign eq_o   = valid && (entry_q == ctrl_i.val);
  assign entry_o = entry_q;

  // insert shifts right past larger entries, delete closes one gap
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o || at_end) begin
        entry_d = ctrl_i.val;
      end
    end else if (ctrl_i.del && ge) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### rtl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: bounded ascending list of 7-bit values
// Insert, delete-all-equal and read-by-position on a row of list cells.
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY cells, each holding one entry and passing it
// to a neighbor when the list opens or closes a gap. An insert or a read
// has its result in the output register in the cycle after it is taken; a
// delete closes one gap per cycle until no equal entry is left, and no new
// request is taken meanwhile. Results sit in an output register; a new
// request is taken only once that register is empty or its result leaves
// in the same cycle.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [6:0] value_i,
  input  logic [3:0] position_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [4:0] entry_count_o,
  output logic [4:0] removed_count_o,
  output logic [6:0] read_value_o
);
  import slid_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DEL
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] del_v_q, del_v_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [4:0]       entry_count_q, entry_count_d;
  logic [4:0]       removed_count_q, removed_count_d;
  logic [6:0]       read_value_q, read_value_d;

  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] eq;

  logic             acc;
  logic             any_match;
  logic             full;
  logic             out_load;
  logic [CNT_W+4:0] pos_ext;
  logic [CNT_W+4:0] fill_ext;
  logic [CNT_W+4:0] cnt_ext;
  logic [CNT_W+4:0] rem_ext;
  logic [VAL_W-1:0] rd_val;

  // request handshake
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign any_match  = |eq;
  assign full       = fill_q == CNT_W'(CAPACITY);

  // control word broadcast to the cells
  always_comb begin
    ctrl.val  = (state_q == S_IDLE) ? value_i : del_v_q;
    ctrl.fill = fill_q;
    ctrl.ins  = acc && (kind_i == KIND_INSERT) && !full;
    ctrl.del  = any_match && ((acc && (kind_i == KIND_DELETE)) || (state_q == S_DEL));
  end

  // row of list cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VAL_W-1:0] left_e;
    logic             left_g;
    logic [VAL_W-1:0] right_e;
    if (k == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = entry[k-1];
      assign left_g = gt[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_body
      assign right_e = entry[k+1];
    end
    slid_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .idx_i         (CNT_W'(k)),
      .left_entry_i  (left_e),
      .left_gt_i     (left_g),
      .right_entry_i (right_e),
      .entry_o       (entry[k]),
      .gt_o          (gt[k]),
      .eq_o          (eq[k])
    );
  end

  // read port: select the entry at the requested position
  assign pos_ext  = {{(CNT_W + 1){1'b0}}, position_i};
  assign fill_ext = {5'b0, fill_q};
  always_comb begin
    rd_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (pos_ext == (CNT_W + 5)'(k)) begin
        rd_val = entry[k];
      end
    end
  end

  // next state, counts and result
  always_comb begin
    state_d         = state_q;
    fill_d          = fill_q;
    rem_d           = rem_q;
    del_v_d         = del_v_q;
    out_load        = 1'b0;
    status_d        = status_q;
    removed_count_d = removed_count_q;
    read_value_d    = read_value_q;

    if (ctrl.ins) begin
      fill_d = fill_q + 1'b1;
    end else if (ctrl.del) begin
      fill_d = fill_q - 1'b1;
    end

    if (acc) begin
      del_v_d = value_i;
      rem_d   = '0;
    end
    if (ctrl.del) begin
      rem_d = ((state_q == S_IDLE) ? '0 : rem_q) + 1'b1;
    end
    rem_ext = {5'b0, rem_q};

    status_d        = ST_DONE;
    removed_count_d = '0;
    read_value_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if ((kind_i == KIND_DELETE) && any_match) begin
            state_d = S_DEL;
          end else begin
            out_load = 1'b1;
            if ((kind_i == KIND_INSERT) && full) begin
              status_d = ST_FULL;
            end else if (kind_i == KIND_READ) begin
              if (pos_ext < fill_ext) begin
                read_value_d = rd_val;
              end else begin
                status_d = ST_BEYOND;
              end
            end
          end
        end
      end
      S_DEL: begin
        if (!any_match) begin
          out_load        = 1'b1;
          removed_count_d = rem_ext[4:0];
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    cnt_ext       = {5'b0, fill_d};
    entry_count_d = cnt_ext[4:0];

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state, counts and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request value and result payload
  always_ff @(posedge clk_i) begin
    del_v_q <= del_v_d;
    if (out_load) begin
      status_q        <= status_d;
      entry_count_q   <= entry_count_d;
      removed_count_q <= removed_count_d;
      read_value_q    <= read_value_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign entry_count_o   = entry_count_q;
  assign removed_count_o = removed_count_q;
  assign read_value_o    = read_value_q;

endmodule

### sim/sorted_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_tb: self-checking bench for the sorted list
// Drives insert, delete and read requests through the valid/ready input,
// keeps a shadow copy of the list to predict every result, and checks each
// result field by field under random idling and one long output stall.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb;
  import slid_pkg::*;

  // kind code the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_REQS  = 1200;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
    logic [3:0] position;
  } list_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic [4:0] removed_count;
    logic [6:0] read_value;
  } list_result_t;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [1:0] kind          = KIND_INSERT;
  logic [6:0] value         = '0;
  logic [3:0] position      = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [1:0] status;
  logic [4:0] entry_count;
  logic [4:0] removed_count;
  logic [6:0] read_value;

  list_req_t    req_q[$];
  list_result_t expected_q[$];
  list_req_t    cur_req;

  // shadow copy of the list contents
  logic [6:0] shadow_list [CAPACITY];
  int         shadow_fill = 0;

  int err_cnt     = 0;
  int result_cnt  = 0;
  int cyc_cnt     = 0;
  int send_gap    = 0;
  int recv_gap    = 0;
  int hold_left   = 0;
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;

  sorted_list_insert_delete DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .value_i        (value),
    .position_i     (position),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .entry_count_o  (entry_count),
    .removed_count_o(removed_count),
    .read_value_o   (read_value)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // apply one request to the shadow list and return its result
  function automatic list_result_t apply_list_op(list_req_t r);
    list_result_t res;
    int at;
    int wr;
    res = '0;
    case (r.kind)
      KIND_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // after any equal values
          at = shadow_fill;
          for (int k = shadow_fill - 1; k >= 0; k--) begin
            if (shadow_list[k] > r.value) at = k;
          end
          for (int k = shadow_fill; k > at; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[at] = r.value;
          shadow_fill++;
        end
      end
      KIND_DELETE: begin
        wr = 0;
        for (int k = 0; k < shadow_fill; k++) begin
          if (shadow_list[k] != r.value) begin
            shadow_list[wr] = shadow_list[k];
            wr++;
          end
        end
        res.removed_count = 5'(shadow_fill - wr);
        shadow_fill = wr;
      end
      KIND_READ: begin
        if (int'(r.position) < shadow_fill) res.read_value = shadow_list[r.position];
        else res.status = ST_BEYOND;
      end
      default: ;
    endcase
    res.entry_count = 5'(shadow_fill);
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len(logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(logic [1:0] k, logic [6:0] v, logic [3:0] p);
    list_req_t r;
    r.kind     = k;
    r.value    = v;
    r.position = p;
    req_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d want %0d", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // random request with content biased toward a phase of growth or shrinkage
  function automatic list_req_t random_req(mix_e mix, int base);
    list_req_t r;
    int pick;
    int ins_pct;
    int del_pct;
    ins_pct = (mix == MIX_GROW) ? 60 : (mix == MIX_SHRINK) ? 25 : 40;
    del_pct = (mix == MIX_GROW) ? 15 : (mix == MIX_SHRINK) ? 45 : 30;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) r.kind = KIND_INSERT;
    else if (pick < ins_pct + del_pct) r.kind = KIND_DELETE;
    else if (pick < 95) r.kind = KIND_READ;
    else r.kind = KIND_UNUSED;
    // narrow value window so duplicates and hits on delete are common
    if ($urandom_range(0, 3) == 0) r.value = 7'($urandom_range(0, 127));
    else r.value = 7'(base + $urandom_range(0, 5));
    r.position = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // stimulus, reset and end of run
  initial begin
    mix_e mix;
    int   base;
    // directed part
    add_req(KIND_READ,   7'd0,   4'd0);    // read on an empty list
    add_req(KIND_DELETE, 7'd5,   4'd0);    // delete of an absent value
    add_req(KIND_UNUSED, 7'd127, 4'd15);   // unused kind
    add_req(KIND_INSERT, 7'd50,  4'd0);
    add_req(KIND_INSERT, 7'd50,  4'd0);    // equal value goes after
    add_req(KIND_INSERT, 7'd0,   4'd0);    // ahead of the first entry
    add_req(KIND_INSERT, 7'd127, 4'd0);    // at the end, above 100
    add_req(KIND_INSERT, 7'd100, 4'd0);
    add_req(KIND_READ,   7'd0,   4'd0);
    add_req(KIND_READ,   7'd0,   4'd4);
    add_req(KIND_READ,   7'd0,   4'd15);   // past the end
    add_req(KIND_DELETE, 7'd50,  4'd0);    // removes both copies
    for (int i = 0; i < 13; i++) add_req(KIND_INSERT, 7'(60 - 5 * i), 4'd0);
    add_req(KIND_INSERT, 7'd1,   4'd0);    // list full, dropped
    add_req(KIND_READ,   7'd0,   4'd15);
    add_req(KIND_DELETE, 7'd127, 4'd0);
    // random part in phases
    mix  = MIX_EVEN;
    base = 0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 40 == 0) begin
        mix  = mix_e'($urandom_range(0, 2));
        base = $urandom_range(0, 122);
      end
      req_q.push_back(random_req(mix, base));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait until every request is taken and every result is back
    @(posedge clk_i);
    while (req_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // request driver
  always @(posedge clk_i) begin : drive_proc
    logic      busy;
    list_req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        expected_q.push_back(apply_list_op(cur_req));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          nxt = req_q.pop_front();
          cur_req  <= nxt;
          kind     <= nxt.kind;
          value    <= nxt.value;
          position <= nxt.position;
          in_valid <= 1'b1;
          send_gap <= idle_len(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk_i) begin : recv_proc
    list_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, entry_count", entry_count, 0);
        end else begin
          want = expected_q.pop_front();
          if (status != want.status) report_mismatch("status", status, want.status);
          if (entry_count != want.entry_count)
            report_mismatch("entry_count", entry_count, want.entry_count);
          if (removed_count != want.removed_count)
            report_mismatch("removed_count", removed_count, want.removed_count);
          if (read_value != want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
        end
        result_cnt++;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap  <= ($urandom_range(0, 2) == 0) ? idle_len(recv_calm) : 0;
      end
    end
  end

  // long receiver hold-off and switching of quiet stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cyc_cnt % 400 == 399) begin
        send_calm <= ($urandom_range(0, 2) == 0);
        recv_calm <= ($urandom_range(0, 2) == 0);
      end
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (cyc_cnt == HOLD_START) hold_left <= HOLD_CYCLES;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

### files.f
rtl/slid_pkg.sv
rtl/slid_cell.sv
rtl/sorted_list_insert_delete.sv
sim/sorted_list_insert_delete_tb.sv
